### hdl/mer_pkg.sv
// Shared constants and types for the midpoint ellipse rasterizer.
package mer_pkg;

    localparam int COORD_BITS = 12;
    localparam int RAD_W      = COORD_BITS - 1;
    localparam int SQ_W       = 2 * RAD_W;
    localparam int OUT_W      = COORD_BITS + 2;
    localparam int COLOR_W    = 24;
    localparam int MUL_B_W    = COORD_BITS + 3;
    localparam int PROD_W     = SQ_W + MUL_B_W;
    localparam int DEC_W      = 3 * RAD_W + 7;

    localparam logic OP_START = 1'b0;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0] cx;
        logic [COORD_BITS-1:0] cy;
        logic [COLOR_W-1:0]    color;
        logic                  last;
    } mer_emit_t;

endpackage

### hdl/mer_mul.sv
// Shared multiplier with registered product.
module mer_mul (
    input  logic                                aclk,
    input  logic [mer_pkg::SQ_W-1:0]            op_a,
    input  logic signed [mer_pkg::MUL_B_W-1:0]  op_b,
    output logic signed [mer_pkg::PROD_W-1:0]   prod
);
    import mer_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= $signed({1'b0, op_a}) * op_b;
    end

    assign prod = prod_reg;

endmodule

### hdl/mer_out.sv
// Result register: forms the four mirrored pixels and holds them until taken.
module mer_out (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               load,
    input  mer_pkg::mer_emit_t                 emit,
    output logic                               free,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [mer_pkg::OUT_W-1:0]   m_px_a,
    output logic signed [mer_pkg::OUT_W-1:0]   m_py_a,
    output logic signed [mer_pkg::OUT_W-1:0]   m_px_b,
    output logic signed [mer_pkg::OUT_W-1:0]   m_py_b,
    output logic signed [mer_pkg::OUT_W-1:0]   m_px_c,
    output logic signed [mer_pkg::OUT_W-1:0]   m_py_c,
    output logic signed [mer_pkg::OUT_W-1:0]   m_px_d,
    output logic signed [mer_pkg::OUT_W-1:0]   m_py_d,
    output logic [mer_pkg::COLOR_W-1:0]        m_out_color,
    output logic                               m_last
);
    import mer_pkg::*;

    logic                valid_reg;
    logic [OUT_W-1:0]    xp_reg, xm_reg, yp_reg, ym_reg;
    logic [COLOR_W-1:0]  color_reg;
    logic                last_reg;
    logic [OUT_W-1:0]    cx_w, cy_w, x_w, y_w;

    assign cx_w = OUT_W'(emit.cx);
    assign cy_w = OUT_W'(emit.cy);
    assign x_w  = OUT_W'(emit.x);
    assign y_w  = OUT_W'(emit.y);

    assign free = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
        if (load) begin
            xp_reg    <= cx_w + x_w;
            xm_reg    <= cx_w - x_w;
            yp_reg    <= cy_w + y_w;
            ym_reg    <= cy_w - y_w;
            color_reg <= emit.color;
            last_reg  <= emit.last;
        end
    end

    assign m_valid     = valid_reg;
    assign m_px_a      = xp_reg;
    assign m_py_a      = yp_reg;
    assign m_px_b      = xp_reg;
    assign m_py_b      = ym_reg;
    assign m_px_c      = xm_reg;
    assign m_py_c      = ym_reg;
    assign m_px_d      = xm_reg;
    assign m_py_d      = yp_reg;
    assign m_out_color = color_reg;
    assign m_last      = last_reg;

endmodule

### hdl/midpoint_ellipse_rasterizer_core.sv
// Top level: sequencer of the midpoint ellipse rasterizer around one shared multiplier.
//
//   channel | direction | handshake          | payload
//   s_      | in        | s_valid / s_ready  | op, center, radii, color
//   m_      | out       | m_valid / m_ready  | four mirrored pixels, color, last
//
// A start transaction runs through accept, two squarings and the initial
// decision term; it emits nothing. A step transaction runs through accept,
// two increments, the update, three checks and emit, with the region two
// seed added where region one hands over to region two; the products run
// one after another through the one multiplier, whose output is registered.
// s_ready is high only while the sequencer waits for a transaction. A
// stalled m_ready holds the sequencer at the emit step only if the previous
// result is still unread. Reset is synchronous, active low, and returns to idle.
module midpoint_ellipse_rasterizer_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_op,
    input  logic [mer_pkg::COORD_BITS-1:0]     s_center_x,
    input  logic [mer_pkg::COORD_BITS-1:0]     s_center_y,
    input  logic [mer_pkg::RAD_W-1:0]          s_radius_x,
    input  logic [mer_pkg::RAD_W-1:0]          s_radius_y,
    input  logic [mer_pkg::COLOR_W-1:0]        s_pixel_color,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [mer_pkg::OUT_W-1:0]   m_px_a,
    output logic signed [mer_pkg::OUT_W-1:0]   m_py_a,
    output logic signed [mer_pkg::OUT_W-1:0]   m_px_b,
    output logic signed [mer_pkg::OUT_W-1:0]   m_py_b,
    output logic signed [mer_pkg::OUT_W-1:0]   m_px_c,
    output logic signed [mer_pkg::OUT_W-1:0]   m_py_c,
    output logic signed [mer_pkg::OUT_W-1:0]   m_px_d,
    output logic signed [mer_pkg::OUT_W-1:0]   m_py_d,
    output logic [mer_pkg::COLOR_W-1:0]        m_out_color,
    output logic                               m_last
);
    import mer_pkg::*;

    typedef enum logic [3:0] {
        ST_WAIT, ST_SQA, ST_SQB, ST_D1, ST_D1F,
        ST_INC1, ST_INC2, ST_UPD, ST_CHK1, ST_CHK2, ST_CHK3, ST_D2, ST_EMIT
    } state_t;

    typedef enum logic [1:0] {PH_IDLE, PH_R1, PH_R2} phase_t;

    state_t                 state_reg, state_next;
    phase_t                 phase_reg, phase_next;
    logic [COORD_BITS-1:0]  x_reg, x_next, y_reg, y_next;
    logic [COORD_BITS-1:0]  ox_reg, ox_next, oy_reg, oy_next;
    logic [DEC_W-1:0]       d_reg, d_next;
    logic [SQ_W-1:0]        a2_reg, a2_next, b2_reg, b2_next;
    logic [RAD_W-1:0]       a_reg, a_next, b_reg, b_next;
    logic [COORD_BITS-1:0]  cx_reg, cx_next, cy_reg, cy_next;
    logic [COLOR_W-1:0]     color_reg, color_next;
    logic                   dge_reg, dge_next;
    logic                   last_reg, last_next;
    logic signed [PROD_W-1:0] pbx_reg, pbx_next;

    logic [SQ_W-1:0]          mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0] mul_prod;
    logic signed [DEC_W-1:0]  prod_ext, prod4;

    // Stepping axis u and cross axis v swap between the two regions, and so
    // do the squared axes P (weights the u term) and Q (weights the v term).
    logic [COORD_BITS-1:0]  u_sel, v_sel;
    logic [SQ_W-1:0]        p_sel, q_sel;
    logic                   in_r1;
    logic                   bx_le_ay;

    logic       s_fire;
    logic       out_free;
    logic       out_load;
    mer_emit_t  emit;

    assign s_ready = (state_reg == ST_WAIT);
    assign s_fire  = s_valid && s_ready;

    assign in_r1 = (phase_reg == PH_R1);
    assign u_sel = in_r1 ? x_reg : y_reg;
    assign v_sel = in_r1 ? y_reg : x_reg;
    assign p_sel = in_r1 ? b2_reg : a2_reg;
    assign q_sel = in_r1 ? a2_reg : b2_reg;

    // Product scaled by four, sign extended to the decision width.
    assign prod_ext = DEC_W'(mul_prod);
    assign prod4    = prod_ext <<< 2;

    assign bx_le_ay = (pbx_reg <= mul_prod);

    mer_mul u_mul (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (mul_prod)
    );

    // Pick the multiplier operands for the product the next state consumes.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_SQA: begin
                mul_a = SQ_W'(a_reg);
                mul_b = MUL_B_W'(a_reg);
            end
            ST_SQB: begin
                mul_a = SQ_W'(b_reg);
                mul_b = MUL_B_W'(b_reg);
            end
            ST_D1: begin
                mul_a = a2_reg;
                mul_b = MUL_B_W'(b_reg);
            end
            ST_INC1: begin
                mul_a = p_sel;
                mul_b = (MUL_B_W'(u_sel) << 1) + MUL_B_W'(3);
            end
            ST_INC2: begin
                mul_a = q_sel;
                mul_b = MUL_B_W'(2) - (MUL_B_W'(v_sel) << 1);
            end
            ST_CHK1: begin
                mul_a = b2_reg;
                mul_b = MUL_B_W'(x_reg);
            end
            ST_CHK2: begin
                mul_a = a2_reg;
                mul_b = MUL_B_W'(y_reg);
            end
            ST_CHK3: begin
                mul_a = b2_reg;
                mul_b = MUL_B_W'(a_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        ox_next    = ox_reg;
        oy_next    = oy_reg;
        d_next     = d_reg;
        a2_next    = a2_reg;
        b2_next    = b2_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        color_next = color_reg;
        dge_next   = dge_reg;
        last_next  = last_reg;
        pbx_next   = pbx_reg;
        out_load   = 1'b0;

        case (state_reg)
            ST_WAIT: begin
                if (s_fire) begin
                    if (s_op == OP_START) begin
                        // Load a new ellipse; a zero semi-axis counts as one.
                        cx_next    = s_center_x;
                        cy_next    = s_center_y;
                        a_next     = (s_radius_x == '0) ? RAD_W'(1) : s_radius_x;
                        b_next     = (s_radius_y == '0) ? RAD_W'(1) : s_radius_y;
                        color_next = s_pixel_color;
                        state_next = ST_SQA;
                    end else if (phase_reg != PH_IDLE) begin
                        // Hold the current point for output, snapshot the sign.
                        ox_next    = x_reg;
                        oy_next    = y_reg;
                        dge_next   = !d_reg[DEC_W-1];
                        last_next  = 1'b0;
                        state_next = ST_INC1;
                    end
                end
            end
            ST_SQA: begin
                state_next = ST_SQB;
            end
            ST_SQB: begin
                a2_next    = mul_prod[SQ_W-1:0];
                state_next = ST_D1;
            end
            ST_D1: begin
                b2_next    = mul_prod[SQ_W-1:0];
                state_next = ST_D1F;
            end
            ST_D1F: begin
                // Region one seed: 4*b2 + a2 - 4*a2*b.
                d_next     = (DEC_W'(b2_reg) << 2) + DEC_W'(a2_reg) - prod4;
                x_next     = '0;
                y_next     = COORD_BITS'(b_reg);
                phase_next = PH_R1;
                state_next = ST_WAIT;
            end
            ST_INC1: begin
                state_next = ST_INC2;
            end
            ST_INC2: begin
                d_next     = d_reg + prod4;
                state_next = ST_UPD;
            end
            ST_UPD: begin
                if (dge_reg) begin
                    d_next = d_reg + prod4;
                end
                // Advance the stepping axis, pull in the cross axis on a
                // non-negative decision.
                if (in_r1) begin
                    x_next = x_reg + COORD_BITS'(1);
                    y_next = y_reg - COORD_BITS'(dge_reg);
                end else begin
                    y_next = y_reg + COORD_BITS'(1);
                    x_next = x_reg - COORD_BITS'(dge_reg);
                end
                state_next = ST_CHK1;
            end
            ST_CHK1: begin
                state_next = ST_CHK2;
            end
            ST_CHK2: begin
                pbx_next   = mul_prod;
                state_next = ST_CHK3;
            end
            ST_CHK3: begin
                state_next = ST_EMIT;
                if (in_r1) begin
                    if (!bx_le_ay) begin
                        // Hand over to region two from (a, 0).
                        x_next     = COORD_BITS'(a_reg);
                        y_next     = '0;
                        phase_next = PH_R2;
                        state_next = ST_D2;
                    end
                end else if (bx_le_ay) begin
                    last_next  = 1'b1;
                    phase_next = PH_IDLE;
                end
            end
            ST_D2: begin
                // Region two seed: 4*a2 + b2 - 4*b2*a.
                d_next     = (DEC_W'(a2_reg) << 2) + DEC_W'(b2_reg) - prod4;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = ST_WAIT;
                end
            end
            default: begin
                state_next = ST_WAIT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_WAIT;
            phase_reg <= PH_IDLE;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
        x_reg     <= x_next;
        y_reg     <= y_next;
        ox_reg    <= ox_next;
        oy_reg    <= oy_next;
        d_reg     <= d_next;
        a2_reg    <= a2_next;
        b2_reg    <= b2_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        cx_reg    <= cx_next;
        cy_reg    <= cy_next;
        color_reg <= color_next;
        dge_reg   <= dge_next;
        last_reg  <= last_next;
        pbx_reg   <= pbx_next;
    end

    assign emit.x     = ox_reg;
    assign emit.y     = oy_reg;
    assign emit.cx    = cx_reg;
    assign emit.cy    = cy_reg;
    assign emit.color = color_reg;
    assign emit.last  = last_reg;

    mer_out u_out (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (out_load),
        .emit        (emit),
        .free        (out_free),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_px_a      (m_px_a),
        .m_py_a      (m_py_a),
        .m_px_b      (m_px_b),
        .m_py_b      (m_py_b),
        .m_px_c      (m_px_c),
        .m_py_c      (m_py_c),
        .m_px_d      (m_px_d),
        .m_py_d      (m_py_d),
        .m_out_color (m_out_color),
        .m_last      (m_last)
    );

endmodule
